// File: sv/dbhsl_pkg.sv
// Shared types, constants and the log2 table function for the dB HSL-to-RGB pixel pipe.
package dbhsl_pkg;

  // normalised values are Q0.16 with room for exactly 1.0
  localparam int NORM_BITS = 17;
  localparam int ONE_Q16   = 65536;
  localparam int DB_W      = 16;
  localparam int ROM_W     = 17;
  localparam int MIX_W     = 19;
  localparam int ANGLE_W   = 26;
  localparam int HH_W      = 22;

  // stage counts of each unit
  localparam int DB_LAT   = 6;
  localparam int NORM_LAT = 1 + NORM_BITS;
  localparam int MIX_LAT  = 3;
  localparam int RAMP_LAT = 7;

  // 10*log10(2) in Q.24
  localparam logic signed [26:0] DB_PER_OCTAVE_Q24 = 27'sd50504453;

  // degrees in Q.16
  localparam logic signed [ANGLE_W-1:0] DEG60  = 26'sd3932160;
  localparam logic signed [ANGLE_W-1:0] DEG120 = 26'sd7864320;
  localparam logic signed [ANGLE_W-1:0] DEG180 = 26'sd11796480;
  localparam logic signed [ANGLE_W-1:0] DEG240 = 26'sd15728640;
  localparam logic signed [ANGLE_W-1:0] DEG360 = 26'sd23592960;

  // floor(2^28 / 60): quotient estimate low by at most one
  localparam logic [22:0] RECIP60     = 23'd4473924;
  localparam int          RECIP_SHIFT = 28;

  typedef struct packed {
    logic vld;
    logic pix;
  } ctl_t;

  typedef enum logic [2:0] {
    REG_HUE_LOW    = 3'd0,
    REG_HUE_HIGH   = 3'd1,
    REG_SAT_LOW    = 3'd2,
    REG_SAT_HIGH   = 3'd3,
    REG_LIGHT_LOW  = 3'd4,
    REG_LIGHT_HIGH = 3'd5
  } cfg_reg_t;

  // log2(1 + idx/2^tbits) in Q0.16, bitwise squaring
  function automatic logic [ROM_W-1:0] log2_entry(input int idx, input int tbits);
    logic [63:0]      y;
    logic [ROM_W-1:0] f;
    begin
      f = '0;
      y = (64'd1 << 30) + ((64'(idx) << 30) >> tbits);
      if (idx == (1 << tbits)) begin
        f = ROM_W'(ONE_Q16);
      end else begin
        for (int k = 0; k < 16; k++) begin
          y = (y * y) >> 30;
          f = f << 1;
          if (y >= (64'd2 << 30)) begin
            f[0] = 1'b1;
            y    = y >> 1;
          end
        end
      end
      return f;
    end
  endfunction

endpackage

// File: sv/dbhsl_to_db.sv
// Float magnitude to signed fixed-point decibels, six register stages.
module dbhsl_to_db #(
  parameter int FRAC_BITS      = 8,
  parameter int LOG_TABLE_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dbhsl_pkg::ctl_t                   in_ctl,
  input  logic [31:0]                       in_bits,
  output dbhsl_pkg::ctl_t                   out_ctl,
  output logic signed [dbhsl_pkg::DB_W-1:0] out_db
);

  localparam int REST_BITS   = 23 - LOG_TABLE_BITS;
  localparam int ROM_ENTRIES = (1 << LOG_TABLE_BITS) + 1;
  localparam int SHIFT       = 40 - FRAC_BITS;
  localparam int ROM_W       = dbhsl_pkg::ROM_W;
  localparam int L2_W        = 26;
  localparam int PROD_W      = 52;
  localparam logic signed [PROD_W-1:0] DB_MAX = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] DB_MIN = -PROD_W'(32768);

  logic [ROM_W-1:0] rom [ROM_ENTRIES];
  for (genvar gi = 0; gi < ROM_ENTRIES; gi++) begin : g_rom
    assign rom[gi] = dbhsl_pkg::log2_entry(gi, LOG_TABLE_BITS);
  end

  // stage 1: field split, leading one of a subnormal mantissa
  dbhsl_pkg::ctl_t ctl1_r, ctl2_r, ctl3_r, ctl4_r, ctl5_r, ctl6_r;
  logic            inf1_r, zero1_r, sub1_r;
  logic [7:0]      exp1_r;
  logic [22:0]     man1_r;
  logic [4:0]      lead1_r, lead_nxt;

  always_comb begin
    lead_nxt = '0;
    for (int i = 0; i < 23; i++) begin
      if (in_bits[i]) lead_nxt = 5'(i);
    end
  end

  // stage 2: unbiased exponent and normalised fraction
  logic              inf2_r, zero2_r;
  logic signed [8:0] ex2_r, ex_nxt;
  logic [22:0]       fr2_r, fr_nxt;

  always_comb begin
    if (sub1_r) begin
      ex_nxt = $signed({4'b0, lead1_r}) - 9'sd149;
      fr_nxt = man1_r << (5'd23 - lead1_r);
    end else begin
      ex_nxt = $signed({1'b0, exp1_r}) - 9'sd127;
      fr_nxt = man1_r;
    end
  end

  // stage 3: table read
  logic                    inf3_r, zero3_r;
  logic signed [8:0]       ex3_r;
  logic [ROM_W-1:0]        base3_r, diff3_r, base_nxt, next_nxt;
  logic [REST_BITS-1:0]    rest3_r;
  logic [LOG_TABLE_BITS:0] idx_w;

  always_comb begin
    idx_w    = {1'b0, fr2_r[22 -: LOG_TABLE_BITS]};
    base_nxt = rom[idx_w];
    next_nxt = rom[idx_w + 1'b1];
  end

  // stage 4: interpolation, log2 in Q.16
  logic                         inf4_r, zero4_r;
  logic signed [L2_W-1:0]       l2_4_r, l2_nxt;
  logic [ROM_W+REST_BITS-1:0]   interp, interp_sh;
  logic [ROM_W-1:0]             lf;

  always_comb begin
    interp    = diff3_r * rest3_r;
    interp_sh = interp >> REST_BITS;
    lf        = base3_r + interp_sh[ROM_W-1:0];
    l2_nxt    = $signed({ex3_r[8], ex3_r, 16'b0}) + $signed({9'b0, lf});
  end

  // stage 5: scale to dB
  logic                     inf5_r, zero5_r;
  logic signed [PROD_W-1:0] prod5_r, prod_nxt;

  always_comb prod_nxt = l2_4_r * dbhsl_pkg::DB_PER_OCTAVE_Q24;

  // stage 6: floor to the output grid and saturate
  logic signed [PROD_W-1:0]             shifted;
  logic signed [dbhsl_pkg::DB_W-1:0]    db6_r, db_nxt;

  always_comb begin
    shifted = prod5_r >>> SHIFT;
    if (inf5_r || shifted > DB_MAX) begin
      db_nxt = 16'sh7FFF;
    end else if (zero5_r || shifted < DB_MIN) begin
      db_nxt = -16'sh8000;
    end else begin
      db_nxt = shifted[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
      ctl5_r <= '0;
      ctl6_r <= '0;
    end else begin
      ctl1_r <= in_ctl;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
      ctl5_r <= ctl4_r;
      ctl6_r <= ctl5_r;
    end
  end

  always_ff @(posedge clk) begin
    inf1_r  <= (in_bits[30:23] == 8'hFF);
    zero1_r <= (in_bits[30:0] == 31'd0);
    sub1_r  <= (in_bits[30:23] == 8'h00);
    exp1_r  <= in_bits[30:23];
    man1_r  <= in_bits[22:0];
    lead1_r <= lead_nxt;

    inf2_r  <= inf1_r;
    zero2_r <= zero1_r;
    ex2_r   <= ex_nxt;
    fr2_r   <= fr_nxt;

    inf3_r  <= inf2_r;
    zero3_r <= zero2_r;
    ex3_r   <= ex2_r;
    base3_r <= base_nxt;
    diff3_r <= next_nxt - base_nxt;
    rest3_r <= fr2_r[REST_BITS-1:0];

    inf4_r  <= inf3_r;
    zero4_r <= zero3_r;
    l2_4_r  <= l2_nxt;

    inf5_r  <= inf4_r;
    zero5_r <= zero4_r;
    prod5_r <= prod_nxt;

    db6_r   <= db_nxt;
  end

  assign out_ctl = ctl6_r;
  assign out_db  = db6_r;

endmodule

// File: sv/dbhsl_norm.sv
// Clamp to the common range and normalise: pipelined restoring divider, one bit a stage.
module dbhsl_norm (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  dbhsl_pkg::ctl_t                        in_ctl,
  input  logic signed [dbhsl_pkg::DB_W-1:0]      in_db,
  input  logic signed [dbhsl_pkg::DB_W-1:0]      lo,
  input  logic signed [dbhsl_pkg::DB_W-1:0]      hi,
  input  logic [dbhsl_pkg::NORM_BITS-1:0]        span,
  input  logic                                   span_zero,
  output dbhsl_pkg::ctl_t                        out_ctl,
  output logic [dbhsl_pkg::NORM_BITS-1:0]        out_q
);

  localparam int QB = dbhsl_pkg::NORM_BITS;

  logic signed [dbhsl_pkg::DB_W-1:0] clamp_nxt;
  logic [QB-1:0]                     num_r, num_nxt;
  logic                              zero0_r;
  dbhsl_pkg::ctl_t                   ctl0_r;

  always_comb begin
    if (in_db > hi) begin
      clamp_nxt = hi;
    end else if (in_db < lo) begin
      clamp_nxt = lo;
    end else begin
      clamp_nxt = in_db;
    end
    num_nxt = QB'($signed({clamp_nxt[15], clamp_nxt}) - $signed({lo[15], lo}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
    end else begin
      ctl0_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    num_r   <= num_nxt;
    zero0_r <= span_zero;
  end

  logic [QB-1:0]   rem_r  [QB];
  logic [QB-1:0]   quo_r  [QB];
  logic            zero_r [QB];
  dbhsl_pkg::ctl_t ctl_r  [QB];

  // first step yields the integer bit (value equals the span), the rest the fraction
  for (genvar gk = 0; gk < QB; gk++) begin : g_step
    logic [QB-1:0]   trial, rem_nxt, quo_in, quo_nxt;
    logic            bit_q, zero_in;
    dbhsl_pkg::ctl_t ctl_in;

    if (gk == 0) begin : g_first
      assign trial   = num_r;
      assign quo_in  = '0;
      assign zero_in = zero0_r;
      assign ctl_in  = ctl0_r;
    end else begin : g_next
      assign trial   = {rem_r[gk-1][QB-2:0], 1'b0};
      assign quo_in  = quo_r[gk-1];
      assign zero_in = zero_r[gk-1];
      assign ctl_in  = ctl_r[gk-1];
    end

    assign bit_q   = (trial >= span);
    assign rem_nxt = bit_q ? trial - span : trial;

    if (gk == QB - 1) begin : g_last
      assign quo_nxt = zero_in ? '0 : {quo_in[QB-2:0], bit_q};
    end else begin : g_mid
      assign quo_nxt = {quo_in[QB-2:0], bit_q};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[gk] <= '0;
      end else begin
        ctl_r[gk] <= ctl_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[gk]  <= rem_nxt;
      quo_r[gk]  <= quo_nxt;
      zero_r[gk] <= zero_in;
    end
  end

  assign out_ctl = ctl_r[QB-1];
  assign out_q   = quo_r[QB-1];

endmodule

// File: sv/dbhsl_ramp.sv
// One colour channel: hue wrap, segment pick, ramp by 1/60 degree, clip and 8-bit floor.
module dbhsl_ramp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  dbhsl_pkg::ctl_t                        in_ctl,
  input  logic signed [dbhsl_pkg::ANGLE_W-1:0]   in_angle,
  input  logic signed [dbhsl_pkg::MIX_W-1:0]     in_m1,
  input  logic signed [dbhsl_pkg::MIX_W-1:0]     in_m2,
  input  logic [dbhsl_pkg::NORM_BITS-1:0]        in_d,
  input  logic [dbhsl_pkg::NORM_BITS-1:0]        in_light,
  input  logic                                   in_grey,
  output dbhsl_pkg::ctl_t                        out_ctl,
  output logic [7:0]                             out_level
);

  localparam int AW = dbhsl_pkg::ANGLE_W;
  localparam int MW = dbhsl_pkg::MIX_W;
  localparam int NB = dbhsl_pkg::NORM_BITS;
  localparam int HW = dbhsl_pkg::HH_W;

  typedef enum logic [1:0] {SEG_RISE, SEG_HIGH, SEG_FALL, SEG_LOW} seg_t;

  typedef struct packed {
    logic signed [MW-1:0] m1;
    logic signed [MW-1:0] m2;
    logic [NB-1:0]        light;
    logic                 grey;
  } mix_t;

  dbhsl_pkg::ctl_t ctl1_r, ctl2_r, ctl3_r, ctl4_r, ctl5_r, ctl6_r, ctl7_r;
  mix_t            mix1_r, mix2_r, mix3_r, mix4_r, mix5_r;

  // stage 1: wrap into 0..360 degrees
  logic signed [AW-1:0] ang1_r, ang_nxt;
  logic [NB-1:0]        d1_r, d2_r;

  always_comb begin
    if (in_angle > dbhsl_pkg::DEG360) begin
      ang_nxt = in_angle - dbhsl_pkg::DEG360;
    end else if (in_angle < 0) begin
      ang_nxt = in_angle + dbhsl_pkg::DEG360;
    end else begin
      ang_nxt = in_angle;
    end
  end

  // stage 2: segment and ramp offset
  seg_t                 seg2_r, seg3_r, seg4_r, seg5_r, seg_nxt;
  logic [HW-1:0]        hh2_r, hh_nxt;
  logic signed [AW-1:0] fall_off;

  always_comb begin
    fall_off = dbhsl_pkg::DEG240 - ang1_r;
    hh_nxt   = '0;
    if (ang1_r < dbhsl_pkg::DEG60) begin
      seg_nxt = SEG_RISE;
      hh_nxt  = ang1_r[HW-1:0];
    end else if (ang1_r < dbhsl_pkg::DEG180) begin
      seg_nxt = SEG_HIGH;
    end else if (ang1_r < dbhsl_pkg::DEG240) begin
      seg_nxt = SEG_FALL;
      hh_nxt  = fall_off[HW-1:0];
    end else begin
      seg_nxt = SEG_LOW;
    end
  end

  // stage 3: span times offset
  logic [NB+HW-1:0] prod3_r;

  // stage 4: drop 2^16, multiply by the reciprocal of 60
  logic [HW-1:0]    y_nxt, y4_r;
  logic [HW+22:0]   qp4_r;

  assign y_nxt = prod3_r[HW+15:16];

  // stage 5: one correction step
  logic [NB-1:0]    qe, q5_r, q_nxt;
  logic [HW:0]      rem_q;

  always_comb begin
    qe    = qp4_r[dbhsl_pkg::RECIP_SHIFT +: NB];
    rem_q = {1'b0, y4_r} - ((HW + 1)'(qe) * (HW + 1)'(60));
    q_nxt = (rem_q >= (HW + 1)'(60)) ? qe + 1'b1 : qe;
  end

  // stage 6: colour value
  logic signed [MW-1:0] v6_r, v_nxt;

  always_comb begin
    case (seg5_r)
      SEG_RISE, SEG_FALL: v_nxt = mix5_r.m1 + $signed({2'b0, q5_r});
      SEG_HIGH:           v_nxt = mix5_r.m2;
      SEG_LOW:            v_nxt = mix5_r.m1;
      default:            v_nxt = mix5_r.m1;
    endcase
    if (mix5_r.grey) v_nxt = $signed({2'b0, mix5_r.light});
  end

  // stage 7: clip to 0..1 and take floor(255 * v); a masked pixel gives 0
  logic [NB-1:0]   clip;
  logic [NB+7:0]   scaled;
  logic [7:0]      level7_r, level_nxt;

  always_comb begin
    if (v6_r < 0) begin
      clip = '0;
    end else if (v6_r > MW'(dbhsl_pkg::ONE_Q16)) begin
      clip = NB'(dbhsl_pkg::ONE_Q16);
    end else begin
      clip = v6_r[NB-1:0];
    end
    scaled    = {clip, 8'b0} - {8'b0, clip};
    level_nxt = ctl6_r.pix ? scaled[23:16] : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
      ctl5_r <= '0;
      ctl6_r <= '0;
      ctl7_r <= '0;
    end else begin
      ctl1_r <= in_ctl;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
      ctl5_r <= ctl4_r;
      ctl6_r <= ctl5_r;
      ctl7_r <= ctl6_r;
    end
  end

  always_ff @(posedge clk) begin
    ang1_r   <= ang_nxt;
    d1_r     <= in_d;
    mix1_r   <= '{m1: in_m1, m2: in_m2, light: in_light, grey: in_grey};

    seg2_r   <= seg_nxt;
    hh2_r    <= hh_nxt;
    d2_r     <= d1_r;
    mix2_r   <= mix1_r;

    prod3_r  <= d2_r * hh2_r;
    seg3_r   <= seg2_r;
    mix3_r   <= mix2_r;

    y4_r     <= y_nxt;
    qp4_r    <= y_nxt * dbhsl_pkg::RECIP60;
    seg4_r   <= seg3_r;
    mix4_r   <= mix3_r;

    q5_r     <= q_nxt;
    seg5_r   <= seg4_r;
    mix5_r   <= mix4_r;

    v6_r     <= v_nxt;
    level7_r <= level_nxt;
  end

  assign out_ctl   = ctl7_r;
  assign out_level = level7_r;

endmodule

// File: sv/db_scaled_hsl_to_rgb_pixel.sv
// Top level: dB-scaled HSL pixel to 8-bit RGB, fully pipelined.
//
//  channel   handshake                     payload
//  --------  ----------------------------  ------------------------------------------
//  request   start, busy                   in_hue/sat/light_sample, in_pixel_valid
//  result    out_strobe (one cycle)        out_red, out_green, out_blue
//  config    cfg_we                        cfg_index, cfg_data
//
// One pixel per clock. A pixel passes through the float-to-dB log unit, the
// bit-per-stage normalising divider, the m1/m2 mix and the colour ramps, in that order.
// busy is high only while rst_n is low; synchronous reset empties the pipe.
// The result side has no back-pressure, so the pipe never stalls.
module db_scaled_hsl_to_rgb_pixel #(
  parameter int FRAC_BITS      = 8,
  parameter int LOG_TABLE_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_hue_sample,
  input  logic [31:0] in_sat_sample,
  input  logic [31:0] in_light_sample,
  input  logic        in_pixel_valid,
  output logic        out_strobe,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int NB = dbhsl_pkg::NORM_BITS;
  localparam int MW = dbhsl_pkg::MIX_W;
  localparam int AW = dbhsl_pkg::ANGLE_W;
  localparam int DW = dbhsl_pkg::DB_W;
  localparam int PIPE_LAT = dbhsl_pkg::DB_LAT + dbhsl_pkg::NORM_LAT +
                            dbhsl_pkg::MIX_LAT + dbhsl_pkg::RAMP_LAT;

  // limit registers
  logic signed [DW-1:0] lim_r [6];
  logic signed [DW-1:0] lo_r, hi_r, lo_nxt, hi_nxt;
  logic [NB-1:0]        span_r;
  logic                 span_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r[0] <= -16'sd10240;
      lim_r[1] <= 16'sd0;
      lim_r[2] <= -16'sd10240;
      lim_r[3] <= 16'sd0;
      lim_r[4] <= -16'sd10240;
      lim_r[5] <= 16'sd0;
    end else if (cfg_we) begin
      case (cfg_index)
        dbhsl_pkg::REG_HUE_LOW:    lim_r[0] <= cfg_data;
        dbhsl_pkg::REG_HUE_HIGH:   lim_r[1] <= cfg_data;
        dbhsl_pkg::REG_SAT_LOW:    lim_r[2] <= cfg_data;
        dbhsl_pkg::REG_SAT_HIGH:   lim_r[3] <= cfg_data;
        dbhsl_pkg::REG_LIGHT_LOW:  lim_r[4] <= cfg_data;
        dbhsl_pkg::REG_LIGHT_HIGH: lim_r[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    lo_nxt = lim_r[0];
    hi_nxt = lim_r[0];
    for (int i = 1; i < 6; i++) begin
      if (lim_r[i] < lo_nxt) lo_nxt = lim_r[i];
      if (lim_r[i] > hi_nxt) hi_nxt = lim_r[i];
    end
  end

  // range follows config through lo_r/hi_r and then span_r, well ahead of the first divider stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r        <= -16'sd10240;
      hi_r        <= 16'sd0;
      span_r      <= NB'(10240);
      span_zero_r <= 1'b0;
    end else begin
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      span_r      <= NB'($signed({hi_r[15], hi_r}) - $signed({lo_r[15], lo_r}));
      span_zero_r <= (hi_r <= lo_r);
    end
  end

  assign busy = ~rst_n;

  dbhsl_pkg::ctl_t      req_ctl;
  dbhsl_pkg::ctl_t      db_ctl_h, db_ctl_s, db_ctl_l, norm_ctl;
  logic signed [DW-1:0] db_h, db_s, db_l;
  logic [NB-1:0]        nh, ns, nl;

  assign req_ctl = '{vld: start & ~busy, pix: in_pixel_valid};

  dbhsl_to_db #(.FRAC_BITS(FRAC_BITS), .LOG_TABLE_BITS(LOG_TABLE_BITS)) u_db_hue (
    .clk, .rst_n, .in_ctl(req_ctl), .in_bits(in_hue_sample),
    .out_ctl(db_ctl_h), .out_db(db_h)
  );
  dbhsl_to_db #(.FRAC_BITS(FRAC_BITS), .LOG_TABLE_BITS(LOG_TABLE_BITS)) u_db_sat (
    .clk, .rst_n, .in_ctl(req_ctl), .in_bits(in_sat_sample),
    .out_ctl(db_ctl_s), .out_db(db_s)
  );
  dbhsl_to_db #(.FRAC_BITS(FRAC_BITS), .LOG_TABLE_BITS(LOG_TABLE_BITS)) u_db_light (
    .clk, .rst_n, .in_ctl(req_ctl), .in_bits(in_light_sample),
    .out_ctl(db_ctl_l), .out_db(db_l)
  );

  dbhsl_norm u_norm_hue (
    .clk, .rst_n, .in_ctl(db_ctl_h), .in_db(db_h), .lo(lo_r), .hi(hi_r),
    .span(span_r), .span_zero(span_zero_r), .out_ctl(norm_ctl), .out_q(nh)
  );
  dbhsl_norm u_norm_sat (
    .clk, .rst_n, .in_ctl(db_ctl_s), .in_db(db_s), .lo(lo_r), .hi(hi_r),
    .span(span_r), .span_zero(span_zero_r), .out_ctl(), .out_q(ns)
  );
  dbhsl_norm u_norm_light (
    .clk, .rst_n, .in_ctl(db_ctl_l), .in_db(db_l), .lo(lo_r), .hi(hi_r),
    .span(span_r), .span_zero(span_zero_r), .out_ctl(), .out_q(nl)
  );

  // mix stage 1: hue in degrees, L*S
  dbhsl_pkg::ctl_t      ctl1_r, ctl2_r, ctl3_r;
  logic signed [AW-1:0] hq1_r, hq2_r, hq_nxt;
  logic [2*NB-1:0]      ls_prod;
  logic [NB-1:0]        p1_r, s1_r, l1_r, l2_r, l3_r;
  logic                 grey1_r, grey2_r, grey3_r;

  always_comb begin
    hq_nxt  = $signed(AW'(nh) * AW'(360));
    ls_prod = nl * ns;
  end

  // mix stage 2: m2
  logic signed [MW-1:0] m2_2_r, m2_nxt, l_ext, s_ext, p_ext;

  always_comb begin
    l_ext = $signed({2'b0, l1_r});
    s_ext = $signed({2'b0, s1_r});
    p_ext = $signed({2'b0, p1_r});
    if (l1_r <= NB'(dbhsl_pkg::ONE_Q16 / 2)) begin
      m2_nxt = l_ext + p_ext;
    end else begin
      m2_nxt = l_ext + s_ext - p_ext;
    end
  end

  // mix stage 3: m1, ramp span, the three hue angles
  logic signed [MW-1:0] m1_3_r, m2_3_r, m1_nxt, d_nxt, l2_ext;
  logic [NB-1:0]        d3_r;
  logic signed [AW-1:0] ang_r_r, ang_g_r, ang_b_r;

  always_comb begin
    l2_ext = $signed({2'b0, l2_r});
    m1_nxt = (l2_ext <<< 1) - m2_2_r;
    d_nxt  = (m2_2_r - l2_ext) <<< 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
    end else begin
      ctl1_r <= norm_ctl;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
    end
  end

  always_ff @(posedge clk) begin
    hq1_r   <= hq_nxt;
    p1_r    <= ls_prod[NB+15:16];
    s1_r    <= ns;
    l1_r    <= nl;
    grey1_r <= (ns == '0);

    hq2_r   <= hq1_r;
    m2_2_r  <= m2_nxt;
    l2_r    <= l1_r;
    grey2_r <= grey1_r;

    m1_3_r  <= m1_nxt;
    m2_3_r  <= m2_2_r;
    d3_r    <= d_nxt[NB-1:0];
    l3_r    <= l2_r;
    grey3_r <= grey2_r;
    ang_r_r <= hq2_r + dbhsl_pkg::DEG120;
    ang_g_r <= hq2_r;
    ang_b_r <= hq2_r - dbhsl_pkg::DEG120;
  end

  dbhsl_pkg::ctl_t out_ctl;

  dbhsl_ramp u_ramp_red (
    .clk, .rst_n, .in_ctl(ctl3_r), .in_angle(ang_r_r), .in_m1(m1_3_r), .in_m2(m2_3_r),
    .in_d(d3_r), .in_light(l3_r), .in_grey(grey3_r), .out_ctl(out_ctl), .out_level(out_red)
  );
  dbhsl_ramp u_ramp_green (
    .clk, .rst_n, .in_ctl(ctl3_r), .in_angle(ang_g_r), .in_m1(m1_3_r), .in_m2(m2_3_r),
    .in_d(d3_r), .in_light(l3_r), .in_grey(grey3_r), .out_ctl(), .out_level(out_green)
  );
  dbhsl_ramp u_ramp_blue (
    .clk, .rst_n, .in_ctl(ctl3_r), .in_angle(ang_b_r), .in_m1(m1_3_r), .in_m2(m2_3_r),
    .in_d(d3_r), .in_light(l3_r), .in_grey(grey3_r), .out_ctl(), .out_level(out_blue)
  );

  assign out_strobe = out_ctl.vld;

  a_req_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_strobe)
    else $error("request did not produce a result after the pipeline latency");

  a_result_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, PIPE_LAT))
    else $error("result strobe without a matching request");

  a_masked_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_ctl.pix) |-> (out_red == 8'd0 && out_green == 8'd0 &&
                                      out_blue == 8'd0))
    else $error("masked pixel is not black");

  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    lo_r <= hi_r)
    else $error("common range low limit above high limit");

endmodule

// File: test/tb_db_scaled_hsl_to_rgb_pixel.sv
// Testbench for the dB-scaled HSL-to-RGB pixel pipe: directed table, random pixels, checked.
`timescale 1ns / 100ps

module tb_db_scaled_hsl_to_rgb_pixel;

  localparam int          PIPE_LAT    = 34;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          PHASE_ITEMS = 265;
  localparam logic [2:0]  REG_UNUSED  = 3'd6;
  localparam logic [31:0] F_ZERO      = 32'h0000_0000;
  localparam logic [31:0] F_NEG_ZERO  = 32'h8000_0000;
  localparam logic [31:0] F_ONE       = 32'h3F80_0000;
  localparam logic [31:0] F_INF       = 32'h7F80_0000;
  localparam logic [31:0] F_NAN       = 32'h7FC0_0001;
  localparam logic [31:0] F_MAX       = 32'h7F7F_FFFF;
  localparam logic [31:0] F_SUB_MIN   = 32'h0000_0001;
  localparam logic [31:0] F_SUB_MAX   = 32'h007F_FFFF;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [31:0] hue;
    logic [31:0] sat;
    logic [31:0] light;
    logic        valid;
    logic        typed;
    rgb_t        color;
  } pixel_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_hue_sample;
  logic [31:0] in_sat_sample;
  logic [31:0] in_light_sample;
  logic        in_pixel_valid;
  logic        out_strobe;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  rgb_t        pending_rgb[$];
  logic [16:0] log2_frac[0:256];
  logic [15:0] limit_db[0:5];
  bit          failed;
  int          idle_pct;
  int unsigned cycles;

  db_scaled_hsl_to_rgb_pixel dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_hue_sample(in_hue_sample), .in_sat_sample(in_sat_sample),
    .in_light_sample(in_light_sample), .in_pixel_valid(in_pixel_valid),
    .out_strobe(out_strobe), .out_red(out_red), .out_green(out_green),
    .out_blue(out_blue), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // log2 fraction table by repeated squaring
  initial begin
    longint unsigned y;
    logic [16:0] f;
    for (int i = 0; i <= 256; i++) begin
      y = (64'd1 << 30) + ((64'(i) << 30) >> 8);
      f = '0;
      for (int k = 0; k < 16; k++) begin
        y = (y * y) >> 30;
        f = f << 1;
        if (y >= (64'd2 << 30)) begin
          f[0] = 1'b1;
          y = y >> 1;
        end
      end
      log2_frac[i] = (i == 256) ? 17'd65536 : f;
    end
  end

  function automatic longint float_to_db(logic [31:0] bits);
    longint ex, fr, idx, rest, lf, l2, prod, db;
    int p;
    if (bits[30:23] == 8'hFF) return 32767;
    if (bits[30:23] == 8'h00) begin
      if (bits[22:0] == 23'd0) return -32768;
      p = 22;
      while (p > 0 && !bits[p]) p--;
      ex = p - 149;
      fr = (longint'(bits[22:0]) << (23 - p)) & 64'h7FFFFF;
    end else begin
      ex = longint'(bits[30:23]) - 127;
      fr = bits[22:0];
    end
    idx  = fr >> 15;
    rest = fr & 64'h7FFF;
    lf   = log2_frac[idx] + (((log2_frac[idx+1] - log2_frac[idx]) * rest) >> 15);
    l2   = ex * 65536 + lf;
    prod = l2 * 50504453;
    // floor toward minus infinity
    if (prod >= 0) db = prod >>> 32;
    else db = -((-prod + 64'hFFFF_FFFF) >>> 32);
    if (db > 32767) db = 32767;
    if (db < -32768) db = -32768;
    return db;
  endfunction

  function automatic longint norm_db(longint x, longint lo, longint hi);
    if (hi <= lo) return 0;
    if (x > hi) x = hi;
    if (x < lo) x = lo;
    return ((x - lo) << 16) / (hi - lo);
  endfunction

  function automatic logic [7:0] ramp_byte(longint h, longint m1, longint m2);
    longint v;
    if (h > 360 * 65536) h -= 360 * 65536;
    else if (h < 0) h += 360 * 65536;
    if (h < 60 * 65536) v = m1 + ((m2 - m1) * h) / (60 * 65536);
    else if (h < 180 * 65536) v = m2;
    else if (h < 240 * 65536) v = m1 + ((m2 - m1) * (240 * 65536 - h)) / (60 * 65536);
    else v = m1;
    if (v > 65536) v = 65536;
    if (v < 0) v = 0;
    return 8'((v * 255) >> 16);
  endfunction

  function automatic rgb_t pixel_rgb(logic [31:0] hue, logic [31:0] sat,
                                     logic [31:0] light, logic valid);
    longint lo, hi, lim, hq, sq, lq, m1, m2;
    rgb_t c;
    c = '0;
    if (!valid) return c;
    lo = $signed(limit_db[0]);
    hi = lo;
    for (int i = 1; i < 6; i++) begin
      lim = $signed(limit_db[i]);
      if (lim < lo) lo = lim;
      if (lim > hi) hi = lim;
    end
    hq = 360 * norm_db(float_to_db(hue), lo, hi);
    sq = norm_db(float_to_db(sat), lo, hi);
    lq = norm_db(float_to_db(light), lo, hi);
    if (lq <= 32768) m2 = (lq * (65536 + sq)) >>> 16;
    else m2 = lq + sq - ((lq * sq) >>> 16);
    m1 = 2 * lq - m2;
    if (sq == 0) begin
      c.r = ramp_byte(90 * 65536, lq, lq);
      c.g = c.r;
      c.b = c.r;
    end else begin
      c.r = ramp_byte(hq + 120 * 65536, m1, m2);
      c.g = ramp_byte(hq, m1, m2);
      c.b = ramp_byte(hq - 120 * 65536, m1, m2);
    end
    return c;
  endfunction

  always @(posedge clk) begin
    rgb_t want;
    if (out_strobe) begin
      if (pending_rgb.size() == 0) begin
        $error("result with no request pending");
        failed = 1'b1;
      end else begin
        want = pending_rgb.pop_front();
        if (out_red !== want.r) begin
          $error("red: expected %0d, got %0d", want.r, out_red);
          failed = 1'b1;
        end
        if (out_green !== want.g) begin
          $error("green: expected %0d, got %0d", want.g, out_green);
          failed = 1'b1;
        end
        if (out_blue !== want.b) begin
          $error("blue: expected %0d, got %0d", want.b, out_blue);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic send_pixel(pixel_row_t row);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_hue_sample   <= row.hue;
    in_sat_sample   <= row.sat;
    in_light_sample <= row.light;
    in_pixel_valid  <= row.valid;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (row.typed) pending_rgb.push_back(row.color);
    else pending_rgb.push_back(pixel_rgb(row.hue, row.sat, row.light, row.valid));
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending_rgb.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 6) @(posedge clk);
  endtask

  // writes all six limits plus one ignored index; pipe must be empty
  task automatic load_limits(logic [15:0] v0, logic [15:0] v1, logic [15:0] v2,
                             logic [15:0] v3, logic [15:0] v4, logic [15:0] v5);
    logic [15:0] vals[0:5];
    vals = '{v0, v1, v2, v3, v4, v5};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= dbhsl_pkg::cfg_reg_t'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      limit_db[i] = vals[i];
    end
    cfg_index <= REG_UNUSED;
    cfg_data  <= 16'(~$urandom());
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(11))
      0: return $urandom();
      1: begin
        case ($urandom_range(5))
          0: return F_ZERO;
          1: return F_NEG_ZERO;
          2: return F_INF | 32'(~$urandom_range(1)) << 31;
          3: return F_NAN | 32'($urandom_range(22'h3FFFFF));
          4: return {$urandom_range(1) == 1, 8'h00, 23'($urandom)};
          default: return F_MAX;
        endcase
      end
      default: return {$urandom_range(1) == 1, 8'($urandom_range(105, 132)), 23'($urandom)};
    endcase
  endfunction

  initial begin
    pixel_row_t directed[] = '{
      '{F_ONE, F_ONE, F_ONE, 1'b0, 1'b1, rgb_t'(24'h000000)},
      '{F_INF, F_INF, F_INF, 1'b0, 1'b1, rgb_t'(24'h000000)},
      '{F_ZERO, F_ZERO, F_ZERO, 1'b1, 1'b1, rgb_t'(24'h000000)},
      '{F_NEG_ZERO, F_NEG_ZERO, F_NEG_ZERO, 1'b1, 1'b1, rgb_t'(24'h000000)},
      '{F_INF, F_INF, F_INF, 1'b1, 1'b1, rgb_t'(24'hFFFFFF)},
      '{F_NAN, F_NAN, F_NAN, 1'b1, 1'b1, rgb_t'(24'hFFFFFF)},
      '{F_ONE, F_ONE, F_ONE, 1'b1, 1'b1, rgb_t'(24'hFFFFFF)},
      '{F_MAX, F_MAX | 32'h8000_0000, F_MAX, 1'b1, 1'b1, rgb_t'(24'hFFFFFF)},
      '{F_ZERO, F_ZERO, F_ONE, 1'b1, 1'b0, rgb_t'(24'h0)},
      '{F_SUB_MIN, F_SUB_MAX, 32'h3F00_0000, 1'b1, 1'b0, rgb_t'(24'h0)},
      '{32'h3DCC_CCCD, 32'h3F00_0000, 32'h3C23_D70A, 1'b1, 1'b0, rgb_t'(24'h0)},
      '{32'h3E80_0000, F_ONE, 32'h3E00_0000, 1'b1, 1'b0, rgb_t'(24'h0)},
      '{32'h3A83_126F, 32'h3951_B717, 32'h3F40_0000, 1'b1, 1'b0, rgb_t'(24'h0)},
      '{32'hB8D1_B717, 32'h3F7F_FFFF, 32'h3D00_0000, 1'b1, 1'b0, rgb_t'(24'h0)},
      '{32'h3C00_0000, 32'h3E4C_CCCD, 32'h3F7F_FFFF, 1'b1, 1'b0, rgb_t'(24'h0)},
      '{32'h3F00_0000, 32'h3D4C_CCCD, 32'h3F00_0000, 1'b1, 1'b0, rgb_t'(24'h0)}
    };
    pixel_row_t row;

    failed          = 1'b0;
    cycles          = 0;
    idle_pct        = 0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_hue_sample   = '0;
    in_sat_sample   = '0;
    in_light_sample = '0;
    in_pixel_valid  = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = dbhsl_pkg::REG_HUE_LOW;
    cfg_data        = '0;
    limit_db        = '{16'hD800, 16'h0000, 16'hD800, 16'h0000, 16'hD800, 16'h0000};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_pixel(directed[i]);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_limits(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        1: load_limits(16'hF000, 16'hF000, 16'hF000, 16'hF000, 16'hF000, 16'hF000);
        2: load_limits(16'hEC00, 16'hF600, 16'hF100, 16'hF800, 16'hEE00, 16'hFB00);
        3: load_limits(16'($urandom), 16'($urandom), 16'($urandom_range(16'hFFFF, 16'hE000)),
                       16'($urandom_range(16'h0400)), 16'hE800, 16'h0800);
        4: load_limits(16'h0000, 16'hD800, 16'hE000, 16'hFC00, 16'hD000, 16'h0400);
        default: load_limits(16'hD800, 16'h0000, 16'hD800, 16'h0000, 16'hD800, 16'h0000);
      endcase
      idle_pct = (ph < 2) ? 34 : (ph < 4) ? 55 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        row.hue   = rand_sample();
        row.sat   = ($urandom_range(15) == 0) ? F_ZERO : rand_sample();
        row.light = rand_sample();
        row.valid = ($urandom_range(9) != 0);
        row.typed = 1'b0;
        row.color = '0;
        // from the middle of each phase idling is switched off, or on where the phase had none
        if (n == PHASE_ITEMS / 2) idle_pct = (idle_pct == 0) ? 34 : 0;
        send_pixel(row);
        // after item 40 of phase 2 the sender holds off until the pipe has emptied
        if (n == 40 && ph == 2) begin
          start <= 1'b0;
          @(posedge clk);
          while (pending_rgb.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (!failed && pending_rgb.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
sv/dbhsl_pkg.sv
sv/dbhsl_to_db.sv
sv/dbhsl_norm.sv
sv/dbhsl_ramp.sv
sv/db_scaled_hsl_to_rgb_pixel.sv
test/tb_db_scaled_hsl_to_rgb_pixel.sv
